// ===== hdl/lmmwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line min/max window filter package
// Widths, register indexes and the shared min/max select used by the filter.
// ----------------------------------------------------------------------------
package lmmwf_pkg;

  localparam int PIX_W    = 8;
  localparam int MAX_HALF = 31;
  localparam int HALF_W   = 5;
  localparam int MODE_W   = 1;

  // History holds the current pixel plus 2*MAX_HALF older ones.
  localparam int HIST_N  = 2 * MAX_HALF + 1;
  localparam int CNT_W   = $clog2(HIST_N + 1);
  localparam int LEAF_N  = 2 ** CNT_W;
  localparam int GRP_LVL = CNT_W / 2;
  localparam int GRP_N   = 2 ** GRP_LVL;
  localparam int PART_N  = LEAF_N / GRP_N;

  localparam int TDATA_W    = ((PIX_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HALF_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HIST_N);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_ERODE  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DILATE = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CNT_W-1:0] hi;    // newest-first history entries 0..hi take part
    logic             last;
  } job_t;

  // Max for dilation, min for erosion.
  function automatic pix_t pick(input pix_t a, input pix_t b, input logic dil);
    pick = dil ? ((a > b) ? a : b) : ((a < b) ? a : b);
  endfunction

endpackage

// ===== hdl/line_min_max_window_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line min/max window filter
// Streaming grayscale erosion/dilation of one image line, flat window 2h+1.
// ----------------------------------------------------------------------------
// One pixel is taken per clock unless a flush or the output holds it off. A
// pixel that is not the last of its line gives the filtered value of the
// position h pixels back once h pixels of the line have gone before it; the
// flagged last pixel flushes every remaining position (min(n, h) + 1 items for
// n earlier pixels), one per clock unless the output stalls, and the input is
// held off while they issue. A result passes the issue, tree half 1 and output
// registers before it is offered. The 64-leaf min/max tree over the pixel
// history is split into two registered halves of eight-input groups. Pixels
// outside the line count as 255 (erosion) or 0 (dilation). Configuration must
// be written only while the filter is idle; the filter does not enforce this.
// ----------------------------------------------------------------------------
module line_min_max_window_filter
  import lmmwf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [7:0] pixel_in
  input  logic                  s_axis_tlast,   // last_in_line
  // Filtered output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [7:0] pixel_out
  output logic                  m_axis_tlast,   // last_out
  // Config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Config registers
  logic [MODE_W-1:0] mode_q;
  logic [HALF_W-1:0] half_q;
  logic              dil;

  // Line state and flush sequencer
  logic [CNT_W-1:0]  rc_q, rc_d;
  logic              fl_busy_q, fl_busy_d;
  logic [HALF_W-1:0] fl_d_q, fl_d_d;
  logic [CNT_W-1:0]  fl_rc_q, fl_rc_d;

  // Pixel history, newest first; entry 0 is the last accepted pixel
  pix_t hist_q [HIST_N];

  // Issue slot
  logic iv_q, iv_d;
  job_t job_q, job_d;

  // Tree half 1
  logic s1v_q;
  logic s1_last_q;
  pix_t part_q [PART_N];
  pix_t part_d [PART_N];
  pix_t leaf   [LEAF_N];

  // Output register
  logic ov_q;
  pix_t opix_q, opix_d;
  logic olast_q;

  // Handshake
  logic acc, in_last, out_rdy, s1_rdy, iss_rdy;
  pix_t in_pix, neutral;

  // Derived job bounds
  logic [CNT_W-1:0]  half_ext, two_h, norm_hi, fl_sum, flush_hi;
  logic [HALF_W-1:0] dmax;

  assign dil     = (mode_q == MODE_DILATE);
  assign neutral = dil ? '0 : '1;
  assign in_pix  = s_axis_tdata[PIX_W-1:0];
  assign in_last = s_axis_tlast;

  // Stall chain: a stage moves when the one after it is empty or moving.
  assign out_rdy       = !ov_q || m_axis_tready;
  assign s1_rdy        = !s1v_q || out_rdy;
  assign iss_rdy       = !iv_q || s1_rdy;
  assign s_axis_tready = !fl_busy_q && iss_rdy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign half_ext = CNT_W'(half_q);
  assign two_h    = CNT_W'({half_q, 1'b0});
  assign norm_hi  = (rc_q < two_h) ? rc_q : two_h;
  assign dmax     = (rc_q < half_ext) ? HALF_W'(rc_q) : half_q;
  assign fl_sum   = CNT_W'(fl_d_q) + half_ext;
  assign flush_hi = (fl_rc_q < fl_sum) ? fl_rc_q : fl_sum;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ERODE;
      half_q <= HALF_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        REG_HALF: half_q <= cfg_data_i[HALF_W-1:0];
        default:  ;
      endcase
    end
  end

  // Line count, flush sequencer and job issue
  always_comb begin
    rc_d      = rc_q;
    fl_busy_d = fl_busy_q;
    fl_d_d    = fl_d_q;
    fl_rc_d   = fl_rc_q;
    iv_d      = iv_q;
    job_d     = job_q;

    if (acc) begin
      if (in_last) begin
        rc_d      = '0;
        fl_busy_d = 1'b1;
        fl_d_d    = dmax;
        fl_rc_d   = rc_q;
      end else if (rc_q != CNT_MAX) begin
        rc_d = rc_q + 1'b1;
      end
    end

    if (iss_rdy) begin
      iv_d = 1'b0;
      if (fl_busy_q) begin
        // flush positions from the oldest pending one down to the last pixel
        iv_d       = 1'b1;
        job_d.hi   = flush_hi;
        job_d.last = (fl_d_q == '0);
        if (fl_d_q == '0) begin
          fl_busy_d = 1'b0;
        end else begin
          fl_d_d = fl_d_q - 1'b1;
        end
      end else if (acc && !in_last && (rc_q >= half_ext)) begin
        iv_d       = 1'b1;
        job_d.hi   = norm_hi;
        job_d.last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q      <= '0;
      fl_busy_q <= 1'b0;
      fl_d_q    <= '0;
      iv_q      <= 1'b0;
    end else begin
      rc_q      <= rc_d;
      fl_busy_q <= fl_busy_d;
      fl_d_q    <= fl_d_d;
      iv_q      <= iv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_rc_q <= fl_rc_d;
    job_q   <= job_d;
  end

  // History shift; held while any issued job still needs it
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hist_q[0] <= in_pix;
      for (int i = 1; i < HIST_N; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // Tree half 1: masked leaves, reduced in groups of GRP_N
  always_comb begin
    for (int j = 0; j < LEAF_N; j++) begin
      leaf[j] = neutral;
    end
    for (int j = 0; j < HIST_N; j++) begin
      if (CNT_W'(j) <= job_q.hi) begin
        leaf[j] = hist_q[j];
      end
    end
    for (int g = 0; g < PART_N; g++) begin
      part_d[g] = leaf[g*GRP_N];
      for (int k = 1; k < GRP_N; k++) begin
        part_d[g] = pick(part_d[g], leaf[g*GRP_N+k], dil);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1v_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_last_q <= job_q.last;
      part_q    <= part_d;
    end
  end

  // Tree half 2: group results down to one pixel
  always_comb begin
    opix_d = part_q[0];
    for (int k = 1; k < PART_N; k++) begin
      opix_d = pick(opix_d, part_q[k], dil);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_rdy) begin
      ov_q <= s1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      opix_q  <= opix_d;
      olast_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = TDATA_W'(opix_q);
  assign m_axis_tlast  = olast_q;

endmodule

// ===== hdl/lmmwf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line min/max window filter checker
// Port-level assertions on output hold, flush stall and line ordering.
// ----------------------------------------------------------------------------
module lmmwf_checker
  import lmmwf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,   // last_in_line
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [TDATA_W-1:0]    m_axis_tdata,   // [7:0] pixel_out
  input logic                  m_axis_tlast,   // last_out
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       in_line_end, out_line_end;
  logic [2:0] pend_q;

  assign in_line_end  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_line_end = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  // Lines taken in whose last item has not left yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, in_line_end} - {2'b00, out_line_end};
    end
  end

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // the flush after a line end always holds off the next pixel
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_line_end |=> !s_axis_tready)
    else $error("input taken right after a line end");

  // a line ends at the output only after it ended at the input
  a_line_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_line_end |-> (pend_q != '0))
    else $error("line end delivered without a pending line");

  // config writes carry a known index and value
  a_cfg_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown(cfg_idx_i) && !$isunknown(cfg_data_i))
    else $error("config write with unknown index or data");

endmodule

bind line_min_max_window_filter lmmwf_checker u_lmmwf_checker (.*);

// ===== verif/tb_line_min_max_window_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line min/max window filter testbench
// Streams image lines through the filter under random back-pressure and checks
// every filtered item against a cycle-free software model of the window.
// ----------------------------------------------------------------------------
// Pixels wait in a queue that the initial block fills phase by phase. Before
// each phase the filter settings are written while the filter is idle. A
// clocked driver presents pixels at the falling edge. The monitor at the
// rising edge runs each accepted pixel through the model, which queues the
// filtered items it expects. Each item taken from the output is compared with
// the oldest queued one. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_line_min_max_window_filter;
  import lmmwf_pkg::*;

  localparam int HIST_D      = 2 * MAX_HALF;      // pixels of history kept
  localparam int CNT_SAT     = 2 * MAX_HALF + 1;  // line count saturates here
  localparam int SETTLE_CYC  = 8;                 // well past the pipeline latency
  localparam int STALL_LIMIT = 2000;              // cycles without any handshake

  typedef struct packed {
    pix_t pix;
    logic last;
  } line_px_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;     // [7:0] pixel_in
  logic                  s_axis_tlast  = 1'b0;   // last_in_line
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;           // [7:0] pixel_out
  logic                  m_axis_tlast;           // last_out
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Stimulus and expectation stores
  line_px_t    pix_q[$];        // pixels not yet presented
  line_px_t    filtered_q[$];   // filtered items still to come out
  int          px_pending;      // pixels pushed but not yet accepted
  line_px_t    drv_px;
  line_px_t    got_px;
  logic        pix_taken = 1'b0;

  // Pacing, in percent of cycles spent idle
  int          src_idle_pct;
  int          snk_idle_pct;
  int          phase_no;

  int          mismatch_cnt;
  int          stall_cyc;

  // Model state: settings, pixel history (newest first), pixels seen in line
  logic        flt_dilate;
  logic [4:0]  flt_half;
  pix_t        line_hist[HIST_D];
  int unsigned line_cnt;

  always #1 clk_i = ~clk_i;

  line_min_max_window_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Model of the window
  // --------------------------------------------------------------------------

  // Min or max over the window centered d pixels behind the current one.
  // Taps past the line start are skipped, which is the neutral fill.
  function automatic pix_t window_extreme(input pix_t cur, input int unsigned d,
                                          input int unsigned h);
    pix_t        acc;
    pix_t        v;
    int unsigned lo;
    acc = flt_dilate ? '0 : '1;
    lo  = (d > h) ? d - h : 0;
    for (int unsigned j = lo; j <= d + h; j++) begin
      if (j > line_cnt) break;
      v = (j == 0) ? cur : line_hist[j-1];
      if (flt_dilate) begin
        if (v > acc) acc = v;
      end else begin
        if (v < acc) acc = v;
      end
    end
    return acc;
  endfunction

  // Queue every filtered item that one accepted pixel causes.
  task automatic filter_pixel(input pix_t cur, input logic last);
    int unsigned h;
    int unsigned dmax;
    line_px_t    res;
    h = flt_half;
    if (!last) begin
      // one item, h positions back, once the window has filled behind it
      if (line_cnt >= h) begin
        res.pix  = window_extreme(cur, h, h);
        res.last = 1'b0;
        filtered_q.push_back(res);
      end
    end else begin
      // flush: every position not yet produced, oldest first
      dmax = (line_cnt < h) ? line_cnt : h;
      for (int k = dmax; k >= 0; k--) begin
        res.pix  = window_extreme(cur, k, h);
        res.last = (k == 0);
        filtered_q.push_back(res);
      end
    end
    for (int i = HIST_D - 1; i > 0; i--) line_hist[i] = line_hist[i-1];
    line_hist[0] = cur;
    if (last) line_cnt = 0;
    else if (line_cnt < CNT_SAT) line_cnt++;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: new pixel or pacing decision at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || pix_taken) begin
      if (pix_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_px = pix_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(drv_px.pix);
        s_axis_tlast  <= drv_px.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= s_axis_tvalid && s_axis_tready;
      // output first: a pixel taken now cannot have an item out yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item pix %0d last %b",
                                    m_axis_tdata[PIX_W-1:0], m_axis_tlast));
        end else begin
          got_px = filtered_q.pop_front();
          if (m_axis_tdata[PIX_W-1:0] !== got_px.pix)
            report_mismatch($sformatf("pixel_out %0d, want %0d",
                                      m_axis_tdata[PIX_W-1:0], got_px.pix));
          if (m_axis_tlast !== got_px.last)
            report_mismatch($sformatf("last_out %b, want %b (pixel %0d)",
                                      m_axis_tlast, got_px.last, got_px.pix));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        filter_pixel(s_axis_tdata[PIX_W-1:0], s_axis_tlast);
        px_pending--;
      end
    end
  end

  // Watchdog on cycles where neither side moves
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_px(input pix_t pix, input logic last);
    line_px_t px;
    px.pix  = pix;
    px.last = last;
    pix_q.push_back(px);
    px_pending++;
  endtask

  // Mostly uniform, with the extremes now and then
  function automatic pix_t rand_pixel();
    if ($urandom_range(7) == 0) return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    return pix_t'($urandom_range(255));
  endfunction

  task automatic push_line(input int len);
    for (int i = 0; i < len; i++) push_px(rand_pixel(), i == len - 1);
  endtask

  // Checked at the falling edge, where queue and counter are settled.
  task automatic wait_idle(input int settle);
    while (px_pending != 0 || filtered_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_MODE) flt_dilate = (data[MODE_W-1:0] == MODE_DILATE);
    else if (idx == REG_HALF) flt_half = data[HALF_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Pacing: receiver-heavy idling, then sender-heavy, then none at all
  task automatic begin_phase(input logic [MODE_W-1:0] mode, input int half);
    if (phase_no < 5) begin
      src_idle_pct = 27;
      snk_idle_pct = 53;
    end else if (phase_no < 10) begin
      src_idle_pct = 53;
      snk_idle_pct = 27;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    phase_no++;
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_HALF, CFG_DATA_W'(half));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    px_pending   = 0;
    mismatch_cnt = 0;
    phase_no     = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    flt_dilate   = (MODE_ERODE == MODE_DILATE);
    flt_half     = 5'd1;
    line_cnt     = 0;
    for (int i = 0; i < HIST_D; i++) line_hist[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Erosion, h = 1: alternating extremes; the sender holds off mid-line
    // until everything in flight has come out. Then two one-pixel lines.
    begin_phase(MODE_ERODE, 1);
    push_px(8'h00, 1'b0);
    push_px(8'hFF, 1'b0);
    push_px(8'h00, 1'b0);
    wait_idle(0);
    push_px(8'hFF, 1'b1);
    push_px(8'hFF, 1'b1);
    push_px(8'h00, 1'b1);
    wait_idle(SETTLE_CYC);

    // Dilation, h = 1
    begin_phase(MODE_DILATE, 1);
    push_px(8'hFF, 1'b0);
    push_px(8'h00, 1'b0);
    push_px(8'h80, 1'b0);
    push_px(8'h01, 1'b1);
    wait_idle(SETTLE_CYC);

    // h = 0: straight pass-through
    begin_phase(MODE_ERODE, 0);
    push_px(8'h55, 1'b0);
    push_px(8'hAA, 1'b0);
    push_px(8'hFF, 1'b1);
    wait_idle(SETTLE_CYC);

    // Widest window on a short line: every window clipped, all on the flush
    begin_phase(MODE_DILATE, MAX_HALF);
    push_px(8'h03, 1'b0);
    push_px(8'hC8, 1'b0);
    push_px(8'h07, 1'b0);
    push_px(8'h00, 1'b0);
    push_px(8'h09, 1'b1);
    push_px(8'hFE, 1'b1);
    wait_idle(SETTLE_CYC);

    // Widest window on a long line: count saturates, flush is the largest
    begin_phase(MODE_ERODE, MAX_HALF);
    push_line(66);
    wait_idle(SETTLE_CYC);

    // Random settings, mostly small windows, one short line each
    for (int p = 0; p < 9; p++) begin
      begin_phase(($urandom_range(1) == 1) ? MODE_DILATE : MODE_ERODE,
                  ($urandom_range(3) == 0) ? $urandom_range(MAX_HALF)
                                           : $urandom_range(4));
      push_line($urandom_range(1, 4));
      wait_idle(SETTLE_CYC);
    end

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
